// File: design/i2cm_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2cm_pkg
// shared types, command codes and sequence lengths of the i2c bit engine
// ----------------------------------------------------------------------------
package i2cm_pkg;

   localparam logic [2:0] FUNC_START = 3'd0;
   localparam logic [2:0] FUNC_STOP  = 3'd1;
   localparam logic [2:0] FUNC_ACK   = 3'd2;
   localparam logic [2:0] FUNC_NACK  = 3'd3;
   localparam logic [2:0] FUNC_WAIT  = 3'd4;
   localparam logic [2:0] FUNC_SEND  = 3'd5;
   localparam logic [2:0] FUNC_READ  = 3'd6;
   localparam logic [2:0] FUNC_NONE  = 3'd7;

   localparam int QUEUE_DEPTH = 2;

   typedef struct packed {
      logic       cmd_start;
      logic [2:0] func;
      logic [7:0] tx_byte;
      logic       sda_in;
   } entry_type;

   typedef struct packed {
      logic       scl_level;
      logic       sda_level;
      logic       busy_res;
      logic       done_res;
      logic [7:0] rx_data;
      logic       ack_seen;
   } rsp_type;

   // index of the last tick of each command sequence
   function automatic logic [4:0] seq_last(input logic [2:0] f);
      logic [4:0] r;
      case (f)
         FUNC_START: r = 5'd1;
         FUNC_STOP:  r = 5'd1;
         FUNC_ACK:   r = 5'd4;
         FUNC_NACK:  r = 5'd2;
         FUNC_WAIT:  r = 5'd2;
         FUNC_SEND:  r = 5'd31;
         FUNC_READ:  r = 5'd23;
         default:    r = 5'd0;
      endcase
      return r;
   endfunction

endpackage

// File: design/i2cm_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2cm interfaces
// valid/ready channels for tick words and result words
// ----------------------------------------------------------------------------
interface i2cm_req_if;
   logic       valid;
   logic       ready;
   logic       cmd_valid;
   logic [2:0] func;
   logic [7:0] tx_byte;
   logic       sda_in;

   modport source (output valid, cmd_valid, func, tx_byte, sda_in, input ready);
   modport sink   (input valid, cmd_valid, func, tx_byte, sda_in, output ready);
endinterface

interface i2cm_rsp_if;
   logic       valid;
   logic       ready;
   logic       scl_level;
   logic       sda_level;
   logic       busy_res;
   logic       done_res;
   logic [7:0] rx_data;
   logic       ack_seen;

   modport source (output valid, scl_level, sda_level, busy_res, done_res, rx_data,
                   ack_seen, input ready);
   modport sink   (input valid, scl_level, sda_level, busy_res, done_res, rx_data,
                   ack_seen, output ready);
endinterface

// File: design/i2cm_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2cm_queue
// short register queue between the tick classifier and the sequencer
// ----------------------------------------------------------------------------
module i2cm_queue import i2cm_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   input  logic      push,
   input  entry_type push_entry,
   output logic      full,
   input  logic      pop,
   output logic      pop_valid,
   output entry_type pop_entry
);

   localparam int PtrW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CntW = $clog2(QUEUE_DEPTH + 1);
   localparam logic [PtrW-1:0] PtrLast = PtrW'(QUEUE_DEPTH - 1);
   localparam logic [CntW-1:0] CntFull = CntW'(QUEUE_DEPTH);

   entry_type       slot_ff [QUEUE_DEPTH];
   logic [PtrW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PtrW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CntW-1:0] count_ff, count_in;
   logic            do_push, do_pop;

   assign full      = (count_ff == CntFull);
   assign pop_valid = (count_ff != '0);
   assign pop_entry = slot_ff[rd_ptr_ff];
   assign do_push   = push && !full;
   assign do_pop    = pop && pop_valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PtrLast) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PtrLast) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

// File: design/i2cm_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2cm_front
// takes tick words and marks the ones that carry a usable command
// ----------------------------------------------------------------------------
module i2cm_front import i2cm_pkg::*; (
   i2cm_req_if.sink  req,
   input  logic      q_full,
   output logic      q_push,
   output entry_type q_entry
);

   assign req.ready = !q_full;
   assign q_push    = req.valid && !q_full;

   always_comb begin
      q_entry.cmd_start = req.cmd_valid && (req.func != FUNC_NONE);
      q_entry.func      = req.func;
      q_entry.tx_byte   = req.tx_byte;
      q_entry.sda_in    = req.sda_in;
   end

endmodule

// File: design/i2cm_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2cm_back
// command sequencer: drives scl/sda per tick and holds the result register
// ----------------------------------------------------------------------------
module i2cm_back import i2cm_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       q_valid,
   input  entry_type  q_entry,
   output logic       q_pop,
   i2cm_rsp_if.source rsp
);

   logic       running_ff, running_in;
   logic [2:0] active_ff, active_in;
   logic [4:0] phase_ff, phase_in;
   logic [1:0] sub_ff, sub_in;
   logic [7:0] shift_ff, shift_in;
   logic       scl_ff, scl_in;
   logic       sda_ff, sda_in;
   logic       ack_ff, ack_in;
   logic [7:0] rx_ff, rx_in;
   logic       out_valid_ff;
   rsp_type    out_ff, out_in;

   logic       advance;
   logic       start;
   logic       run;
   logic       done;
   logic [2:0] cmd;
   logic [4:0] p;
   logic [1:0] sub;
   logic [7:0] shift_cur;

   assign advance = q_valid && (!out_valid_ff || rsp.ready);
   assign q_pop   = advance;

   always_comb begin
      start     = q_entry.cmd_start && !running_ff;
      run       = start || running_ff;
      cmd       = start ? q_entry.func : active_ff;
      p         = start ? 5'd0 : phase_ff;
      sub       = start ? 2'd0 : sub_ff;
      shift_cur = shift_ff;
      if (start && (q_entry.func == FUNC_SEND)) begin
         shift_cur = q_entry.tx_byte;
      end else if (start && (q_entry.func == FUNC_READ)) begin
         shift_cur = 8'h00;
      end

      running_in = running_ff;
      active_in  = cmd;
      phase_in   = phase_ff;
      sub_in     = sub_ff;
      shift_in   = shift_cur;
      scl_in     = scl_ff;
      sda_in     = sda_ff;
      ack_in     = ack_ff;
      rx_in      = rx_ff;
      done       = 1'b0;

      if (run) begin
         unique case (cmd)
            FUNC_START: begin
               scl_in = 1'b1;
               sda_in = (p == 5'd0);
            end
            FUNC_STOP: begin
               scl_in = 1'b1;
               sda_in = (p != 5'd0);
            end
            FUNC_ACK: begin
               scl_in = (p == 5'd2);
               sda_in = (p == 5'd0) || (p >= 5'd4);
            end
            FUNC_NACK: begin
               scl_in = (p == 5'd1);
               sda_in = 1'b1;
            end
            FUNC_WAIT: begin
               scl_in = (p == 5'd1);
               sda_in = 1'b1;
               if (p == 5'd1) begin
                  ack_in = q_entry.sda_in;
               end
            end
            FUNC_SEND: begin
               if (p[1:0] == 2'd0) begin
                  scl_in = 1'b0;
                  sda_in = 1'b0;
               end else begin
                  scl_in = (p[1:0] == 2'd2);
                  sda_in = shift_cur[7];
                  if (p[1:0] == 2'd3) begin
                     shift_in = {shift_cur[6:0], 1'b0};
                  end
               end
            end
            FUNC_READ: begin
               scl_in = (sub == 2'd1);
               if (sub == 2'd1) begin
                  shift_in = {shift_cur[6:0], q_entry.sda_in};
               end
            end
            default: begin
            end
         endcase

         done = (p >= seq_last(cmd));
         if (done) begin
            running_in = 1'b0;
            phase_in   = 5'd0;
            sub_in     = 2'd0;
            if (cmd == FUNC_READ) begin
               rx_in = shift_in;
            end
         end else begin
            running_in = 1'b1;
            phase_in   = p + 5'd1;
            sub_in     = (sub == 2'd2) ? 2'd0 : sub + 2'd1;
         end
      end

      out_in.scl_level = scl_in;
      out_in.sda_level = sda_in;
      out_in.busy_res  = run;
      out_in.done_res  = done;
      out_in.rx_data   = rx_in;
      out_in.ack_seen  = ack_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         running_ff   <= 1'b0;
         active_ff    <= FUNC_START;
         phase_ff     <= 5'd0;
         sub_ff       <= 2'd0;
         shift_ff     <= 8'h00;
         scl_ff       <= 1'b1;
         sda_ff       <= 1'b1;
         ack_ff       <= 1'b0;
         rx_ff        <= 8'h00;
         out_valid_ff <= 1'b0;
      end else begin
         if (advance) begin
            running_ff <= running_in;
            active_ff  <= active_in;
            phase_ff   <= phase_in;
            sub_ff     <= sub_in;
            shift_ff   <= shift_in;
            scl_ff     <= scl_in;
            sda_ff     <= sda_in;
            ack_ff     <= ack_in;
            rx_ff      <= rx_in;
            out_valid_ff <= 1'b1;
         end else if (rsp.ready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         out_ff <= out_in;
      end
   end

   assign rsp.valid     = out_valid_ff;
   assign rsp.scl_level = out_ff.scl_level;
   assign rsp.sda_level = out_ff.sda_level;
   assign rsp.busy_res  = out_ff.busy_res;
   assign rsp.done_res  = out_ff.done_res;
   assign rsp.rx_data   = out_ff.rx_data;
   assign rsp.ack_seen  = out_ff.ack_seen;

endmodule

// File: design/i2c_master_bit_engine.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2c_master_bit_engine
// bit level of an i2c master: one tick word in, one line-level word out
//
//   channel   dir  word
//   req_chan  in   cmd_valid, func, tx_byte, sda_in
//   rsp_chan  out  scl_level, sda_level, busy_res, done_res, rx_data, ack_seen
//
// one word per clock sustained while rsp_chan is ready; a result passes the
// queue slot and then the result register before it is offered
// synchronous reset releases both lines high and leaves the sequencer idle
// a two-word queue parts the classifier from the sequencer; a waiting result
// holds the sequencer, which takes the next tick in the cycle the result leaves
// ----------------------------------------------------------------------------
module i2c_master_bit_engine import i2cm_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   i2cm_req_if.sink   req_chan,
   i2cm_rsp_if.source rsp_chan
);

   logic      q_full;
   logic      q_push;
   entry_type q_push_entry;
   logic      q_pop;
   logic      q_valid;
   entry_type q_pop_entry;

   i2cm_front u_front (
      .req     (req_chan),
      .q_full  (q_full),
      .q_push  (q_push),
      .q_entry (q_push_entry)
   );

   i2cm_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_entry (q_push_entry),
      .full       (q_full),
      .pop        (q_pop),
      .pop_valid  (q_valid),
      .pop_entry  (q_pop_entry)
   );

   i2cm_back u_back (
      .clock   (clock),
      .reset   (reset),
      .q_valid (q_valid),
      .q_entry (q_pop_entry),
      .q_pop   (q_pop),
      .rsp     (rsp_chan)
   );

endmodule
